// ===== rtl/assert_macros.svh =====
// Assertion helpers for the RTL folder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// ===== rtl/pptc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package pptc_pkg;
	localparam int Capacity  = 256;
	localparam int ValueBits = 16;
	localparam int AddrBits  = $clog2(Capacity);
	localparam int CountBits = AddrBits + 1;

	typedef logic [ValueBits-1:0] value_t;
	typedef logic [AddrBits-1:0]  addr_t;
	typedef logic [CountBits-1:0] count_t;

	typedef enum logic [2:0] {
		VERDICT_NOT_SURE   = 3'd0,
		VERDICT_IMPOSSIBLE = 3'd1,
		VERDICT_STACK      = 3'd2,
		VERDICT_QUEUE      = 3'd3,
		VERDICT_HEAP       = 3'd4
	} verdict_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_READ_HEADS,
		ST_CHECK,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_LAST_RD,
		ST_DN_LAST,
		ST_DN_RD_L,
		ST_DN_RD_R,
		ST_DN_CMP,
		ST_DONE
	} state_t;
endpackage
`default_nettype wire

// ===== rtl/push_pop_trace_classifier.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Push/pop trace classifier.
// Command channel: raise start with op, value and last_of_case while busy is
// low; that edge is the transfer. busy stays high until the result is shown.
// Result channel: stack_ok, queue_ok, heap_ok, verdict and overflow are valid
// for exactly one cycle while done is high. The receiver cannot stall; it
// must take each result in that cycle.
// Sequence: a push sifts the new key up the heap (ST_UP_RD, ST_UP_CMP for
// each level walked) unless the heap is full. A pop reads the heads
// (ST_READ_HEADS), checks them (ST_CHECK) and, when the heap root is removed
// and the heap does not empty, reads the last slot (ST_DN_LAST_RD,
// ST_DN_LAST) and sifts it down (ST_DN_RD_L, ST_DN_RD_R, ST_DN_CMP for each
// level). The next transfer can come in the cycle after done. The heap
// memory takes one read or write per cycle. Stack and queue heads are read
// in parallel.
// Reset (arst_n low) empties all three models, sets the three match flags
// and clears overflow. Store contents are not cleared; counts bound reads.
// An item with last_of_case set returns to that reset state after its
// result is shown.
module push_pop_trace_classifier
	import pptc_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	input  wire logic       op,
	input  wire logic [15:0] value,
	input  wire logic       last_of_case,
	output logic            busy,
	output logic            done,
	output logic            stack_ok,
	output logic            queue_ok,
	output logic            heap_ok,
	output logic [2:0]      verdict,
	output logic            overflow
);
	`include "assert_macros.svh"

	// memories
	value_t stack_mem [Capacity];
	value_t fifo_mem  [Capacity];
	value_t heap_mem  [Capacity];

	state_t state_q, state_d;

	count_t stack_cnt_q, fifo_cnt_q, heap_cnt_q;
	addr_t  fifo_head_q, fifo_tail_q;
	logic [2:0] flags_q;
	logic   ovf_q;

	logic   last_q;
	value_t val_q;
	value_t key_q;      // value being sifted
	count_t idx_q;      // current heap slot (fits count width for 2i+1 math)
	count_t child_q;
	value_t left_q;

	// heap port
	logic   h_we, h_re;
	addr_t  h_waddr, h_raddr;
	value_t h_wdata, h_rdata;
	// stack/fifo reads
	value_t s_rdata, f_rdata;

	always_ff @(posedge clk) begin
		if (h_we)
			heap_mem[h_waddr] <= h_wdata;
		if (h_re)
			h_rdata <= heap_mem[h_raddr];
	end

	wire logic push_go = (state_q == ST_IDLE) && start && (op == OP_PUSH);
	wire logic s_push = push_go && (stack_cnt_q != count_t'(Capacity));
	wire logic f_push = push_go && (fifo_cnt_q != count_t'(Capacity));
	addr_t s_top;
	assign s_top = addr_t'(stack_cnt_q - 1'b1);

	always_ff @(posedge clk) begin
		if (s_push)
			stack_mem[addr_t'(stack_cnt_q)] <= value;
		s_rdata <= stack_mem[s_top];
		if (f_push)
			fifo_mem[fifo_tail_q] <= value;
		f_rdata <= fifo_mem[fifo_head_q];
	end

	wire logic [2:0] flags_out = flags_q;
	wire logic s_hit = (stack_cnt_q != '0) && (s_rdata == val_q);
	wire logic f_hit = (fifo_cnt_q != '0) && (f_rdata == val_q);
	wire logic h_hit = (heap_cnt_q != '0) && (h_rdata == val_q);

	count_t parent;
	assign parent = (idx_q - 1'b1) >> 1;
	logic [CountBits:0] lchild;
	assign lchild = {idx_q, 1'b1};

	always_comb begin
		state_d = state_q;
		h_we = 1'b0;
		h_re = 1'b0;
		h_waddr = '0;
		h_raddr = '0;
		h_wdata = key_q;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op == OP_PUSH) begin
						if (heap_cnt_q == count_t'(Capacity))
							state_d = ST_DONE;
						else
							state_d = ST_UP_RD;
					end else begin
						h_re = 1'b1;
						h_raddr = '0;
						state_d = ST_READ_HEADS;
					end
				end
			end
			ST_READ_HEADS: state_d = ST_CHECK;
			ST_CHECK: begin
				if (h_hit && heap_cnt_q != count_t'(1)) begin
					h_re = 1'b1;
					h_raddr = addr_t'(heap_cnt_q - 1'b1);
					state_d = ST_DN_LAST_RD;
				end else
					state_d = ST_DONE;
			end
			ST_UP_RD: begin
				if (idx_q == '0) begin
					h_we = 1'b1;
					h_waddr = '0;
					state_d = ST_DONE;
				end else begin
					h_re = 1'b1;
					h_raddr = addr_t'(parent);
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				if (h_rdata >= key_q) begin
					h_we = 1'b1;
					h_waddr = addr_t'(idx_q);
					state_d = ST_DONE;
				end else begin
					h_we = 1'b1;
					h_waddr = addr_t'(idx_q);
					h_wdata = h_rdata;
					state_d = ST_UP_RD;
				end
			end
			ST_DN_LAST_RD: state_d = ST_DN_LAST;
			ST_DN_LAST: state_d = ST_DN_RD_L;
			ST_DN_RD_L: begin
				if (lchild >= {1'b0, heap_cnt_q}) begin
					h_we = 1'b1;
					h_waddr = addr_t'(idx_q);
					state_d = ST_DONE;
				end else begin
					h_re = 1'b1;
					h_raddr = addr_t'(lchild);
					state_d = ST_DN_RD_R;
				end
			end
			ST_DN_RD_R: begin
				h_re = 1'b1;
				h_raddr = addr_t'(lchild + 1'b1);
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				// h_rdata = right child if it exists, left_q = left child
				if ((lchild + 1'b1) < {1'b0, heap_cnt_q} && h_rdata > left_q) begin
					if (h_rdata <= key_q) begin
						h_we = 1'b1;
						h_waddr = addr_t'(idx_q);
						state_d = ST_DONE;
					end else begin
						h_we = 1'b1;
						h_waddr = addr_t'(idx_q);
						h_wdata = h_rdata;
						state_d = ST_DN_RD_L;
					end
				end else if (left_q <= key_q) begin
					h_we = 1'b1;
					h_waddr = addr_t'(idx_q);
					state_d = ST_DONE;
				end else begin
					h_we = 1'b1;
					h_waddr = addr_t'(idx_q);
					h_wdata = left_q;
					state_d = ST_DN_RD_L;
				end
			end
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	// index and key registers (payload)
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					val_q <= value;
					last_q <= last_of_case;
					key_q <= value;
					idx_q <= heap_cnt_q;
				end
			end
			ST_CHECK: idx_q <= '0;
			ST_UP_CMP: if (h_rdata < key_q) idx_q <= parent;
			ST_DN_LAST: key_q <= h_rdata;
			ST_DN_RD_R: left_q <= h_rdata;
			ST_DN_CMP: begin
				if ((lchild + 1'b1) < {1'b0, heap_cnt_q} && h_rdata > left_q)
					idx_q <= count_t'(lchild + 1'b1);
				else
					idx_q <= count_t'(lchild);
			end
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stack_cnt_q <= '0;
			fifo_cnt_q <= '0;
			heap_cnt_q <= '0;
			fifo_head_q <= '0;
			fifo_tail_q <= '0;
			flags_q <= 3'b111;
			ovf_q <= 1'b0;
		end else if (state_q == ST_DONE && last_q) begin
			stack_cnt_q <= '0;
			fifo_cnt_q <= '0;
			heap_cnt_q <= '0;
			fifo_head_q <= '0;
			fifo_tail_q <= '0;
			flags_q <= 3'b111;
			ovf_q <= 1'b0;
		end else if (state_q == ST_IDLE && start && op == OP_PUSH) begin
			if (s_push)
				stack_cnt_q <= stack_cnt_q + 1'b1;
			if (f_push) begin
				fifo_cnt_q <= fifo_cnt_q + 1'b1;
				fifo_tail_q <= fifo_tail_q + 1'b1;
			end
			if (heap_cnt_q != count_t'(Capacity))
				heap_cnt_q <= heap_cnt_q + 1'b1;
			if (!s_push || !f_push || heap_cnt_q == count_t'(Capacity))
				ovf_q <= 1'b1;
		end else if (state_q == ST_CHECK) begin
			if (s_hit)
				stack_cnt_q <= stack_cnt_q - 1'b1;
			else
				flags_q[0] <= 1'b0;
			if (f_hit) begin
				fifo_cnt_q <= fifo_cnt_q - 1'b1;
				fifo_head_q <= fifo_head_q + 1'b1;
			end else
				flags_q[1] <= 1'b0;
			if (h_hit)
				heap_cnt_q <= heap_cnt_q - 1'b1;
			else
				flags_q[2] <= 1'b0;
		end
	end

	always_comb begin
		done = (state_q == ST_DONE);
		busy = (state_q != ST_IDLE);
		stack_ok = flags_out[0];
		queue_ok = flags_out[1];
		heap_ok = flags_out[2];
		overflow = ovf_q;
		case (flags_out)
			3'b000: verdict = VERDICT_IMPOSSIBLE;
			3'b001: verdict = VERDICT_STACK;
			3'b010: verdict = VERDICT_QUEUE;
			3'b100: verdict = VERDICT_HEAP;
			default: verdict = VERDICT_NOT_SURE;
		endcase
	end

	`ASSERT_IMPL(a_cnt_bound, clk, arst_n, 1'b1, heap_cnt_q <= count_t'(Capacity) && stack_cnt_q <= count_t'(Capacity), "count beyond capacity")
	`ASSERT_NEXT(a_flags_sticky, clk, arst_n, state_q != ST_DONE, (flags_q & ~$past(flags_q)) == 3'b000, "match flag set without clear")
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "result shown twice")
	`ASSERT_IMPL(a_fifo_ptrs, clk, arst_n, 1'b1, fifo_cnt_q == count_t'(Capacity) || addr_t'(fifo_tail_q - fifo_head_q) == addr_t'(fifo_cnt_q), "fifo pointers disagree with count")
endmodule
`default_nettype wire

// ===== tb/sv/pptc_checker.sv =====
`timescale 1ns / 1ps
module pptc_checker
	import pptc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic        op,
	input  logic [15:0] value,
	input  logic        last_of_case,
	input  logic        done,
	input  logic        stack_ok,
	input  logic        queue_ok,
	input  logic        heap_ok,
	input  logic [2:0]  verdict,
	input  logic        overflow,
	output int          fail_count,
	output int          pending,
	output int          result_count
);
	typedef struct packed {
		logic     s_ok;
		logic     q_ok;
		logic     h_ok;
		verdict_t verd;
		logic     ovf;
	} outcome_t;

	outcome_t outcome_q[$];

	value_t lifo[Capacity];
	int     lifo_n;
	value_t ring[Capacity];
	int     ring_rd, ring_wr, ring_n;
	value_t pq[Capacity];
	int     pq_n;
	logic [2:0] alive;
	logic       ovf_seen;

	function automatic void clear_models();
		lifo_n = 0;
		ring_rd = 0;
		ring_wr = 0;
		ring_n = 0;
		pq_n = 0;
		alive = 3'b111;
		ovf_seen = 1'b0;
	endfunction

	function automatic void pq_insert(value_t v);
		int i, p;
		i = pq_n;
		pq_n++;
		while (i > 0) begin
			p = (i - 1) / 2;
			if (pq[p] >= v)
				break;
			pq[i] = pq[p];
			i = p;
		end
		pq[i] = v;
	endfunction

	function automatic void pq_drop_top();
		int i, c;
		value_t v;
		i = 0;
		pq_n--;
		if (pq_n == 0)
			return;
		v = pq[pq_n];
		forever begin
			c = 2 * i + 1;
			if (c >= pq_n)
				break;
			if (c + 1 < pq_n && pq[c+1] > pq[c])
				c++;
			if (pq[c] <= v)
				break;
			pq[i] = pq[c];
			i = c;
		end
		pq[i] = v;
	endfunction

	function automatic outcome_t classify(logic o, value_t v, logic last);
		outcome_t r;
		int n;
		if (o == OP_PUSH) begin
			if (lifo_n < Capacity) begin
				lifo[lifo_n] = v;
				lifo_n++;
			end else
				ovf_seen = 1'b1;
			if (ring_n < Capacity) begin
				ring[ring_wr] = v;
				ring_wr = (ring_wr + 1) % Capacity;
				ring_n++;
			end else
				ovf_seen = 1'b1;
			if (pq_n < Capacity)
				pq_insert(v);
			else
				ovf_seen = 1'b1;
		end else begin
			if (lifo_n == 0 || lifo[lifo_n-1] != v)
				alive[0] = 1'b0;
			else
				lifo_n--;
			if (ring_n == 0 || ring[ring_rd] != v)
				alive[1] = 1'b0;
			else begin
				ring_rd = (ring_rd + 1) % Capacity;
				ring_n--;
			end
			if (pq_n == 0 || pq[0] != v)
				alive[2] = 1'b0;
			else
				pq_drop_top();
		end
		n = alive[0] + alive[1] + alive[2];
		if (n >= 2)
			r.verd = VERDICT_NOT_SURE;
		else if (n == 0)
			r.verd = VERDICT_IMPOSSIBLE;
		else if (alive[0])
			r.verd = VERDICT_STACK;
		else if (alive[1])
			r.verd = VERDICT_QUEUE;
		else
			r.verd = VERDICT_HEAP;
		r.s_ok = alive[0];
		r.q_ok = alive[1];
		r.h_ok = alive[2];
		r.ovf = ovf_seen;
		if (last)
			clear_models();
		return r;
	endfunction

	initial begin
		fail_count = 0;
		result_count = 0;
		pending = 0;
		clear_models();
	end

	always @(posedge clk) begin
		outcome_t want;
		if (arst_n) begin
			if (done) begin
				result_count++;
				if (outcome_q.size() == 0) begin
					$error("result with no transfer pending");
					fail_count++;
				end else begin
					want = outcome_q.pop_front();
					if (stack_ok !== want.s_ok) begin
						$error("stack_ok exp %0d got %0d", want.s_ok, stack_ok);
						fail_count++;
					end
					if (queue_ok !== want.q_ok) begin
						$error("queue_ok exp %0d got %0d", want.q_ok, queue_ok);
						fail_count++;
					end
					if (heap_ok !== want.h_ok) begin
						$error("heap_ok exp %0d got %0d", want.h_ok, heap_ok);
						fail_count++;
					end
					if (verdict !== want.verd) begin
						$error("verdict exp %0d got %0d", want.verd, verdict);
						fail_count++;
					end
					if (overflow !== want.ovf) begin
						$error("overflow exp %0d got %0d", want.ovf, overflow);
						fail_count++;
					end
				end
			end
			if (start && !busy)
				outcome_q.push_back(classify(op, value, last_of_case));
			pending = outcome_q.size();
		end
	end
endmodule

// ===== tb/sv/push_pop_trace_classifier_tb.sv =====
`timescale 1ns / 1ps
module push_pop_trace_classifier_tb;
	import pptc_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        op = OP_PUSH;
	logic [15:0] value = '0;
	logic        last_of_case = 1'b0;
	logic        busy, done, stack_ok, queue_ok, heap_ok, overflow;
	logic [2:0]  verdict;
	int          fail_count, pending, result_count;
	int          transfers = 0;
	int          traces = 0;
	int          burst_left = 0;

	// 8 ns clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	push_pop_trace_classifier dut (
		.clk, .arst_n, .start, .op, .value, .last_of_case,
		.busy, .done, .stack_ok, .queue_ok, .heap_ok, .verdict, .overflow
	);

	// Predicts every transfer and compares each done strobe against it.
	pptc_checker u_chk (
		.clk, .arst_n, .start, .busy, .op, .value, .last_of_case,
		.done, .stack_ok, .queue_ok, .heap_ok, .verdict, .overflow,
		.fail_count, .pending, .result_count
	);

	// Present one item from a falling edge and hold it until it transfers.
	// Between bursts a random gap; within a burst start stays up back to back.
	task automatic send_item(input logic o, input logic [15:0] v, input logic last);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
			if (gap > 0) begin
				start <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		start <= 1'b1;
		op <= o;
		value <= v;
		last_of_case <= last;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		transfers++;
		if (last)
			traces++;
		@(negedge clk);
		// start remains high; next call or the end lowers it
	endtask

	task automatic idle_line();
		start <= 1'b0;
		op <= 1'($urandom_range(0, 1));
		value <= 16'($urandom());
		last_of_case <= 1'($urandom_range(0, 1));
	endtask

	// Pushes N random values and pops them back in the order one model would
	// give, so that model survives; some pops are corrupted to rule it out.
	task automatic model_trace(input int kind, input int n, input int vmax);
		logic [15:0] vals[$];
		logic [15:0] v;
		int i, j, best, pops;
		for (i = 0; i < n; i++) begin
			v = 16'($urandom_range(0, vmax));
			vals.push_back(v);
			send_item(OP_PUSH, v, 1'b0);
		end
		pops = $urandom_range(0, n + 1);
		for (i = 0; i < pops; i++) begin
			if (vals.size() == 0)
				v = 16'($urandom());
			else if (kind == 0)
				v = vals.pop_back();
			else if (kind == 1)
				v = vals.pop_front();
			else begin
				best = 0;
				for (j = 1; j < vals.size(); j++)
					if (vals[j] > vals[best])
						best = j;
				v = vals[best];
				vals.delete(best);
			end
			if ($urandom_range(0, 15) == 0)
				v = 16'($urandom());
			send_item(OP_POP, v, i == pops - 1 && $urandom_range(0, 1));
		end
		// Random pushes and pops as noise, then close the trace.
		for (i = $urandom_range(0, 3); i > 0; i--)
			send_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, vmax)), 1'b0);
		send_item(OP_POP, 16'($urandom_range(0, vmax)), 1'b1);
	endtask

	initial begin
		int i, k;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed: empty pop, extremes, and distinguishing traces.
		send_item(OP_POP, 16'h0000, 1'b1);
		send_item(OP_PUSH, 16'hFFFF, 1'b0);
		send_item(OP_PUSH, 16'h0000, 1'b0);
		send_item(OP_PUSH, 16'h8001, 1'b0);
		send_item(OP_POP, 16'h8001, 1'b0);  // stack only
		send_item(OP_POP, 16'h0000, 1'b1);
		send_item(OP_PUSH, 16'h0001, 1'b0);
		send_item(OP_PUSH, 16'h0005, 1'b0);
		send_item(OP_POP, 16'h0001, 1'b0);  // queue only
		send_item(OP_POP, 16'h0005, 1'b1);
		send_item(OP_PUSH, 16'h0003, 1'b0);
		send_item(OP_PUSH, 16'h0009, 1'b0);
		send_item(OP_PUSH, 16'h0001, 1'b0);
		send_item(OP_POP, 16'h0009, 1'b0);  // heap only
		send_item(OP_POP, 16'h1234, 1'b0);  // nothing matches
		send_item(OP_PUSH, 16'h7777, 1'b0);
		send_item(OP_POP, 16'h7777, 1'b1);  // ruled-out models stay out

		// Fill past capacity: overflow, then pop six values in stack order.
		for (i = 0; i < Capacity + 2; i++)
			send_item(OP_PUSH, 16'(i), 1'b0);
		for (i = 0; i < 6; i++)
			send_item(OP_POP, 16'(Capacity - 1 - i), 1'b0);
		send_item(OP_PUSH, 16'hABCD, 1'b1);

		// Random traces: mostly well formed for one model, often a small value range
		// so duplicates make the models agree at times.
		k = 0;
		while (k < 170) begin
			i = $urandom_range(0, 9);
			if (i < 8) begin
				model_trace(i % 3, $urandom_range(1, 10),
					($urandom_range(0, 1)) ? 7 : 16'hFFFF);
				k += 12;
			end else begin
				send_item(1'($urandom_range(0, 1)), 16'($urandom()),
					$urandom_range(0, 7) == 0);
				k++;
			end
		end
		idle_line();

		while (pending != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("%0d transfers over %0d closed traces, %0d results checked",
			transfers, traces, result_count);
		if (fail_count == 0)
			$display("push_pop_trace_classifier verification clean");
		else
			$display("push_pop_trace_classifier verification failed");
		$finish;
	end

	initial begin
		#20ms;
		$display("push_pop_trace_classifier verification failed");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+rtl
rtl/pptc_pkg.sv
rtl/push_pop_trace_classifier.sv
tb/sv/pptc_checker.sv
tb/sv/push_pop_trace_classifier_tb.sv
